[src/pvhp_pkg.sv]
// Shared types and constants for the pixel value histogram block.
// No dependencies; every module of the block imports this package.
package pvhp_pkg;

   localparam int CHANNELS      = 4;
   localparam int CH_W          = 2;
   localparam int SAMPLE_W      = 8;
   localparam int SAMPLE_VALUES = 256;

   localparam int FUNC_W = 2;
   localparam logic [FUNC_W-1:0] FUNC_ACCUMULATE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ       = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 2'd2;

   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_GRAY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RGB  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CMYK = 2'd2;

   localparam int TOTAL_W     = 25;
   localparam int COUNT_OUT_W = 25;
   localparam int PCT_W       = 23;
   // 100 percent in Q7.16
   localparam logic [PCT_W-1:0] PCT_SCALE = 23'd6553600;
   localparam logic [PCT_W-1:0] PCT_MAX   = '1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 25;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_TOTAL = 1'd1;

   typedef struct packed {
      logic busy;
      logic done;
   } pvhp_div_status_type;

   function automatic logic channel_active(input logic [MODE_W-1:0] mode,
                                           input logic [CH_W-1:0] ch);
      logic act;
      act = 1'b1;
      if (ch == CH_W'(3)) begin
         act = (mode != MODE_GRAY) && (mode != MODE_RGB);
      end else if (ch != CH_W'(0)) begin
         act = (mode != MODE_GRAY);
      end
      return act;
   endfunction

endpackage

[src/pixel_value_histogram_percent.sv]
// Accumulate: one transfer per cycle while ready (no clearing pass or read in
// flight), bins read-modify-written the cycle after, with forwarding. Clear:
// a clearing pass, no input taken meanwhile. Read: memory read, multiply,
// range check, up to 23 quotient steps (pvhp_percent) to the result register;
// one read in flight. Reset starts a clearing pass over all channel memories;
// configuration writes are taken during it. Depends on pvhp_pkg, pvhp_percent.
module pixel_value_histogram_percent
   import pvhp_pkg::*;
#(
   parameter int COUNT_BITS = 25,
   parameter int BIN_COUNT  = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [FUNC_W-1:0]       req_func,
   input  logic [SAMPLE_W-1:0]     req_sample_0,
   input  logic [SAMPLE_W-1:0]     req_sample_1,
   input  logic [SAMPLE_W-1:0]     req_sample_2,
   input  logic [SAMPLE_W-1:0]     req_sample_3,
   input  logic [CH_W-1:0]         req_read_channel,
   input  logic [SAMPLE_W-1:0]     req_read_bin,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [COUNT_OUT_W-1:0]  rsp_bin_count,
   output logic [PCT_W-1:0]        rsp_bin_percent,
   output logic                    rsp_channel_inactive
);

   localparam int IDX_W = $clog2(BIN_COUNT);
   localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

   logic [MODE_W-1:0]     color_mode_ff, color_mode_in;
   logic [TOTAL_W-1:0]    pixel_total_ff, pixel_total_in;

   logic                  sweep_ff, sweep_in;
   logic [IDX_W-1:0]      sweep_addr_ff, sweep_addr_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_read_ff, s1_read_in;
   logic [CHANNELS-1:0]   s1_act_ff, s1_act_in;
   logic [IDX_W-1:0]      s1_addr_ff [CHANNELS];
   logic [IDX_W-1:0]      s1_addr_in [CHANNELS];
   logic [CH_W-1:0]       s1_rch_ff, s1_rch_in;
   logic                  s1_inactive_ff, s1_inactive_in;

   logic [IDX_W-1:0]      bin_of [SAMPLE_VALUES];
   logic [SAMPLE_W-1:0]   sample [CHANNELS];
   logic [IDX_W-1:0]      rd_addr [CHANNELS];
   logic [COUNT_BITS-1:0] rd_data_ff [CHANNELS];
   logic [COUNT_BITS-1:0] cur_count [CHANNELS];
   logic [CHANNELS-1:0]   wr_en;
   logic [IDX_W-1:0]      wr_addr [CHANNELS];
   logic [COUNT_BITS-1:0] wr_data [CHANNELS];
   logic [CHANNELS-1:0]   fwd_valid_ff;
   logic [IDX_W-1:0]      fwd_addr_ff [CHANNELS];
   logic [COUNT_BITS-1:0] fwd_data_ff [CHANNELS];

   logic                  req_take;
   logic                  div_start;
   logic                  div_take;
   logic [COUNT_BITS-1:0] div_count;
   pvhp_div_status_type   div_st;
   logic [PCT_W-1:0]      div_percent;

   logic [COUNT_BITS-1:0] pend_count_ff, pend_count_in;
   logic                  pend_inactive_ff, pend_inactive_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [PCT_W-1:0]      rsp_percent_ff, rsp_percent_in;
   logic                  rsp_inactive_ff, rsp_inactive_in;

   // sample value to bin index, folded at elaboration
   for (genvar g = 0; g < SAMPLE_VALUES; g++) begin : g_bin_of
      assign bin_of[g] = IDX_W'(g % BIN_COUNT);
   end

   assign sample[0] = req_sample_0;
   assign sample[1] = req_sample_1;
   assign sample[2] = req_sample_2;
   assign sample[3] = req_sample_3;

   assign req_take  = req_valid && req_ready;
   assign req_ready = !sweep_ff && !div_st.busy && !(s1_valid_ff && s1_read_ff);

   // configuration
   always_comb begin
      color_mode_in  = color_mode_ff;
      pixel_total_in = pixel_total_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_COLOR_MODE:  color_mode_in  = csr_data[MODE_W-1:0];
            CSR_PIXEL_TOTAL: pixel_total_in = csr_data[TOTAL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // clearing pass
   always_comb begin
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
         if (sweep_addr_ff == IDX_W'(BIN_COUNT - 1)) begin
            sweep_in = 1'b0;
         end
      end
      if (req_take && req_func == FUNC_CLEAR) begin
         sweep_in      = 1'b1;
         sweep_addr_in = '0;
      end
   end

   // memory read stage
   always_comb begin
      s1_valid_in    = req_take && (req_func == FUNC_ACCUMULATE || req_func == FUNC_READ);
      s1_read_in     = (req_func == FUNC_READ);
      s1_rch_in      = req_read_channel;
      s1_inactive_in = !channel_active(color_mode_ff, req_read_channel);
      for (int c = 0; c < CHANNELS; c++) begin
         s1_act_in[c]  = (req_func == FUNC_ACCUMULATE) &&
                         channel_active(color_mode_ff, CH_W'(c));
         rd_addr[c]    = (req_func == FUNC_ACCUMULATE) ? bin_of[sample[c]]
                                                       : bin_of[req_read_bin];
         s1_addr_in[c] = rd_addr[c];
      end
   end

   // per-channel bins with read-modify-write and forwarding
   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      logic [COUNT_BITS-1:0] bins_mem [BIN_COUNT];

      always_ff @(posedge clock) begin
         if (wr_en[c]) begin
            bins_mem[wr_addr[c]] <= wr_data[c];
         end
         if (req_take) begin
            rd_data_ff[c] <= bins_mem[rd_addr[c]];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            fwd_valid_ff[c] <= 1'b0;
         end else begin
            fwd_valid_ff[c] <= wr_en[c];
         end
         fwd_addr_ff[c] <= wr_addr[c];
         fwd_data_ff[c] <= wr_data[c];
      end

      assign cur_count[c] = (fwd_valid_ff[c] && fwd_addr_ff[c] == s1_addr_ff[c])
                            ? fwd_data_ff[c] : rd_data_ff[c];
      assign wr_en[c]     = sweep_ff || (s1_valid_ff && s1_act_ff[c]);
      assign wr_addr[c]   = sweep_ff ? sweep_addr_ff : s1_addr_ff[c];
      assign wr_data[c]   = sweep_ff ? '0 :
                            (cur_count[c] == COUNT_FULL) ? cur_count[c]
                                                         : cur_count[c] + 1'b1;
   end

   // percentage of a read bin
   assign div_start = s1_valid_ff && s1_read_ff;
   assign div_count = cur_count[s1_rch_ff];
   assign div_take  = div_st.done && (!rsp_valid_ff || rsp_ready);

   pvhp_percent #(
      .COUNT_BITS (COUNT_BITS)
   ) u_percent (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .count   (div_count),
      .divisor (pixel_total_ff),
      .take    (div_take),
      .status  (div_st),
      .percent (div_percent)
   );

   // result register
   always_comb begin
      pend_count_in    = div_start ? div_count : pend_count_ff;
      pend_inactive_in = div_start ? s1_inactive_ff : pend_inactive_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_count_in     = rsp_count_ff;
      rsp_percent_in   = rsp_percent_ff;
      rsp_inactive_in  = rsp_inactive_ff;
      if (div_take) begin
         rsp_valid_in    = 1'b1;
         rsp_count_in    = COUNT_OUT_W'(pend_count_ff);
         rsp_percent_in  = div_percent;
         rsp_inactive_in = pend_inactive_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff  <= MODE_GRAY;
         pixel_total_ff <= TOTAL_W'(1);
         sweep_ff       <= 1'b1;
         sweep_addr_ff  <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         color_mode_ff  <= color_mode_in;
         pixel_total_ff <= pixel_total_in;
         sweep_ff       <= sweep_in;
         sweep_addr_ff  <= sweep_addr_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      s1_read_ff       <= s1_read_in;
      s1_act_ff        <= s1_act_in;
      s1_addr_ff       <= s1_addr_in;
      s1_rch_ff        <= s1_rch_in;
      s1_inactive_ff   <= s1_inactive_in;
      pend_count_ff    <= pend_count_in;
      pend_inactive_ff <= pend_inactive_in;
      rsp_count_ff     <= rsp_count_in;
      rsp_percent_ff   <= rsp_percent_in;
      rsp_inactive_ff  <= rsp_inactive_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_bin_count        = rsp_count_ff;
   assign rsp_bin_percent      = rsp_percent_ff;
   assign rsp_channel_inactive = rsp_inactive_ff;

   a_sweep_alone: assert property (@(posedge clock) disable iff (reset)
      sweep_ff |-> !s1_valid_ff)
      else $error("bin update during clearing pass");

   a_clear_sweeps: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_func == FUNC_CLEAR) |=> sweep_ff && sweep_addr_ff == '0)
      else $error("clear transfer did not start a clearing pass");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(div_st.done))
      else $error("result without a finished percentage");

   a_one_read: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_st.busy)
      else $error("second read reached the percent unit");

endmodule

[src/pvhp_percent.sv]
// Percentage unit: count * 100 / pixel_total in Q7.16, saturating.
// One constant multiply, a range check, then one restoring quotient bit per cycle.
// Depends on pvhp_pkg.
module pvhp_percent
   import pvhp_pkg::*;
#(
   parameter int COUNT_BITS = 25
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [COUNT_BITS-1:0]     count,
   input  logic [TOTAL_W-1:0]        divisor,
   input  logic                      take,
   output pvhp_div_status_type       status,
   output logic [PCT_W-1:0]          percent
);

   localparam int NUM_W  = COUNT_BITS + PCT_W;
   localparam int DEN_W  = TOTAL_W + PCT_W;
   localparam int WIDE_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;
   localparam int STEP_W = $clog2(PCT_W);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_RUN   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]            st_ff, st_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [TOTAL_W-1:0]    den_ff, den_in;
   logic [WIDE_W-1:0]     rem_ff, rem_in;
   logic [WIDE_W-1:0]     dsh_ff, dsh_in;
   logic [PCT_W-1:0]      quot_ff, quot_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [NUM_W-1:0]      product;
   logic [WIDE_W-1:0]     limit;
   logic                  fits;

   assign product = NUM_W'(cnt_ff) * NUM_W'(PCT_SCALE);
   assign limit   = WIDE_W'(den_ff) << PCT_W;
   assign fits    = (rem_ff >= dsh_ff);

   always_comb begin
      st_in   = st_ff;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (start) begin
               cnt_in = count;
               den_in = divisor;
               st_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            rem_in = WIDE_W'(product);
            st_in  = ST_CHECK;
         end
         ST_CHECK: begin
            // quotient of 2^23 or more, zero divisor included
            if (rem_ff >= limit) begin
               quot_in = PCT_MAX;
               st_in   = ST_DONE;
            end else begin
               dsh_in  = WIDE_W'(den_ff) << (PCT_W - 1);
               step_in = '0;
               st_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (fits) begin
               rem_in = rem_ff - dsh_ff;
            end
            quot_in = {quot_ff[PCT_W-2:0], fits};
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(PCT_W - 1)) begin
               st_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
      cnt_ff  <= cnt_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign status.busy = (st_ff != ST_IDLE);
   assign status.done = (st_ff == ST_DONE);
   assign percent     = quot_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> st_ff == ST_IDLE)
      else $error("percent unit started while busy");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_RUN |-> rem_ff < (dsh_ff << 1))
      else $error("partial remainder out of range");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DONE && !take) |=> st_ff == ST_DONE && $stable(quot_ff))
      else $error("result lost before transfer");

endmodule
